// ===== rtl/core/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg - shared types and constants of the IPv4 forwarding decision block
// Table sizes, action and verdict codes, and the item, result and memory
// entry structs.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int ROUTE_DEPTH    = 64;
  localparam int NEIGHBOR_DEPTH = 16;
  localparam int PORT_BITS      = 4;

  localparam int ROUTE_AW = $clog2(ROUTE_DEPTH);
  localparam int NBR_AW   = $clog2(NEIGHBOR_DEPTH);
  localparam int NBR_CW   = $clog2(NEIGHBOR_DEPTH + 1);

  localparam logic [ROUTE_AW:0]   ROUTE_END  = (ROUTE_AW + 1)'(ROUTE_DEPTH);
  localparam logic [ROUTE_AW-1:0] ROUTE_LAST = ROUTE_AW'(ROUTE_DEPTH - 1);
  localparam logic [NBR_CW-1:0]   NBR_FULL   = NBR_CW'(NEIGHBOR_DEPTH);

  // action codes
  localparam logic [1:0] ACT_ROUTE_WR  = 2'd0;
  localparam logic [1:0] ACT_NBR_LEARN = 2'd1;
  localparam logic [1:0] ACT_LOOKUP    = 2'd2;

  // verdict codes
  localparam logic [2:0] V_DONE            = 3'd0;
  localparam logic [2:0] V_FORWARD         = 3'd1;
  localparam logic [2:0] V_TIME_EXCEEDED   = 3'd2;
  localparam logic [2:0] V_UNREACHABLE     = 3'd3;
  localparam logic [2:0] V_NEED_RESOLUTION = 3'd4;
  localparam logic [2:0] V_FULL            = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  route_slot;
    logic [31:0] ip_value;
    logic [31:0] mask_value;
    logic [31:0] hop_address;
    logic [3:0]  port_number;
    logic [47:0] mac_value;
    logic [7:0]  ttl_in;
  } item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [3:0]  out_port;
    logic [31:0] next_hop_out;
    logic [47:0] dest_mac;
    logic [7:0]  ttl_out;
  } result_t;

  typedef struct packed {
    logic [31:0]          prefix;
    logic [31:0]          mask;
    logic [31:0]          hop;
    logic [PORT_BITS-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } nbr_entry_t;

endpackage

// ===== rtl/core/ifd_ram.sv =====
// ----------------------------------------------------------------------------
// ifd_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ifd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ipv4_forwarding_decision.sv =====
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision - route and neighbor lookup for IPv4 forwarding
// Longest-prefix route search over a route RAM, then a first-match search
// of the next hop over a neighbor RAM.
// ----------------------------------------------------------------------------
// A beat is taken on start while busy is low; each beat gives exactly one
// result, shown on result for one cycle with done high. The receiver cannot
// stall it. Route writes, neighbor learns, unused actions and lookups that
// fail the TTL check answer in the cycle after the beat, and busy stays low.
// A lookup walks the route RAM one entry a cycle at its single read port.
// If a route matches and neighbors are known, it then walks the neighbor
// RAM, one entry a cycle, stopping at the first hit or at the last learned
// entry. busy stays high until the cycle in which the result shows, and
// the next beat can be taken in that cycle. Route valid bits sit in
// flip-flops cleared by reset; the entry RAMs are not cleared.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ifd_pkg::item_t  item,
  output logic            done,
  output ifd_pkg::result_t result
);

  import ifd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUTE = 2'd1;
  localparam logic [1:0] ST_NBR   = 2'd2;

  logic [1:0] state;

  // lookup context
  logic [31:0] dst;
  logic [7:0]  ttl;

  // route scan
  logic [ROUTE_AW:0]          r_issue;
  logic                       r_pend;
  logic [ROUTE_AW-1:0]        r_eval;
  logic [ROUTE_DEPTH-1:0]     route_valid;
  logic                       have_best;
  logic [31:0]                best_mask;
  logic [31:0]                best_hop;
  logic [PORT_BITS-1:0]       best_port;

  // neighbor scan
  logic [NBR_CW-1:0] nbr_count;
  logic [NBR_CW-1:0] n_issue;
  logic              n_pend;
  logic [NBR_AW-1:0] n_eval;

  // memory ports
  logic                r_wr_en;
  logic [ROUTE_AW-1:0] r_wr_addr;
  route_entry_t        r_wr_data;
  route_entry_t        r_rd;
  logic                n_wr_en;
  nbr_entry_t          n_wr_data;
  nbr_entry_t          n_rd;

  logic                 accept;
  logic                 slot_ok;
  logic                 nbr_room;
  logic                 take;
  logic                 final_have;
  logic [31:0]          final_hop;
  logic [PORT_BITS-1:0] final_port;
  logic                 route_last;
  logic                 n_hit;
  logic                 nbr_last;
  logic                 done_next;
  result_t              result_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign slot_ok   = (32'(item.route_slot) < 32'(ROUTE_DEPTH));
  assign r_wr_en   = accept && (item.action == ACT_ROUTE_WR) && slot_ok;
  assign r_wr_addr = ROUTE_AW'(item.route_slot);
  assign r_wr_data = '{prefix: item.ip_value, mask: item.mask_value,
                       hop: item.hop_address, port: PORT_BITS'(item.port_number)};

  assign nbr_room  = (nbr_count < NBR_FULL);
  assign n_wr_en   = accept && (item.action == ACT_NBR_LEARN) && nbr_room;
  assign n_wr_data = '{ip: item.ip_value, mac: item.mac_value};

  ifd_ram #(
    .WIDTH($bits(route_entry_t)),
    .DEPTH(ROUTE_DEPTH)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (r_wr_en),
    .wr_addr (r_wr_addr),
    .wr_data (r_wr_data),
    .rd_addr (r_issue[ROUTE_AW-1:0]),
    .rd_data (r_rd)
  );

  ifd_ram #(
    .WIDTH($bits(nbr_entry_t)),
    .DEPTH(NEIGHBOR_DEPTH)
  ) u_nbr_ram (
    .clk     (clk),
    .wr_en   (n_wr_en),
    .wr_addr (nbr_count[NBR_AW-1:0]),
    .wr_data (n_wr_data),
    .rd_addr (n_issue[NBR_AW-1:0]),
    .rd_data (n_rd)
  );

  // Route entry returned this cycle: a match with a strictly larger mask
  // wins, so equal masks keep the lower index.
  assign take = r_pend && route_valid[r_eval] &&
                ((dst & r_rd.mask) == r_rd.prefix) &&
                (!have_best || (r_rd.mask > best_mask));
  assign final_have = have_best || take;
  assign final_hop  = take ? r_rd.hop  : best_hop;
  assign final_port = take ? r_rd.port : best_port;
  assign route_last = r_pend && (r_eval == ROUTE_LAST);

  assign n_hit    = n_pend && (n_rd.ip == best_hop);
  assign nbr_last = n_hit || (n_pend && (n_eval == NBR_AW'(nbr_count - 1'b1)));

  // result of the beat that finishes this cycle
  always_comb begin
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.action)
            ACT_ROUTE_WR: begin
              done_next = 1'b1;
            end
            ACT_NBR_LEARN: begin
              done_next = 1'b1;
              if (!nbr_room) begin
                result_next.verdict = V_FULL;
              end
            end
            ACT_LOOKUP: begin
              if (item.ttl_in <= 8'd1) begin
                done_next           = 1'b1;
                result_next.verdict = V_TIME_EXCEEDED;
                result_next.ttl_out = item.ttl_in;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_ROUTE: begin
        if (route_last) begin
          if (!final_have) begin
            done_next           = 1'b1;
            result_next.verdict = V_UNREACHABLE;
            result_next.ttl_out = ttl;
          end else if (nbr_count == '0) begin
            done_next                = 1'b1;
            result_next.verdict      = V_NEED_RESOLUTION;
            result_next.out_port     = 4'(final_port);
            result_next.next_hop_out = final_hop;
            result_next.ttl_out      = ttl - 8'd1;
          end
        end
      end

      ST_NBR: begin
        if (nbr_last) begin
          done_next                = 1'b1;
          result_next.out_port     = 4'(best_port);
          result_next.next_hop_out = best_hop;
          result_next.ttl_out      = ttl - 8'd1;
          if (n_hit) begin
            result_next.verdict  = V_FORWARD;
            result_next.dest_mac = n_rd.mac;
          end else begin
            result_next.verdict  = V_NEED_RESOLUTION;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      route_valid <= '0;
      nbr_count   <= '0;
      r_pend      <= 1'b0;
      n_pend      <= 1'b0;
      have_best   <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.action)
              ACT_ROUTE_WR: begin
                if (slot_ok) begin
                  route_valid[r_wr_addr] <= 1'b1;
                end
              end
              ACT_NBR_LEARN: begin
                if (nbr_room) begin
                  nbr_count <= nbr_count + 1'b1;
                end
              end
              ACT_LOOKUP: begin
                if (item.ttl_in > 8'd1) begin
                  dst       <= item.ip_value;
                  ttl       <= item.ttl_in;
                  r_issue   <= '0;
                  r_pend    <= 1'b0;
                  have_best <= 1'b0;
                  state     <= ST_ROUTE;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_ROUTE: begin
          // compare side
          if (take) begin
            have_best <= 1'b1;
            best_mask <= r_rd.mask;
            best_hop  <= r_rd.hop;
            best_port <= r_rd.port;
          end
          // last entry back: finish here or move on to the neighbors
          if (route_last) begin
            r_pend <= 1'b0;
            if (!final_have || (nbr_count == '0)) begin
              state <= ST_IDLE;
            end else begin
              n_issue <= '0;
              n_pend  <= 1'b0;
              state   <= ST_NBR;
            end
          end else if (r_issue < ROUTE_END) begin
            // issue side: one read per cycle
            r_issue <= r_issue + 1'b1;
            r_eval  <= r_issue[ROUTE_AW-1:0];
            r_pend  <= 1'b1;
          end else begin
            r_pend <= 1'b0;
          end
        end

        ST_NBR: begin
          if (nbr_last) begin
            n_pend <= 1'b0;
            state  <= ST_IDLE;
          end else if (n_issue < nbr_count) begin
            n_issue <= n_issue + 1'b1;
            n_eval  <= n_issue[NBR_AW-1:0];
            n_pend  <= 1'b1;
          end else begin
            n_pend <= 1'b0;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/ifd_checker.sv =====
// ----------------------------------------------------------------------------
// ifd_checker - result checker for the IPv4 forwarding decision block
// Watches the start/busy and done channels and keeps its own copy of the
// route and neighbor tables. It predicts the answer to every accepted beat,
// then compares each answer field by field, oldest first.
// ----------------------------------------------------------------------------
module ifd_checker
  import ifd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  item_t      item,
  input  logic       done,
  input  result_t    result,
  output int         fail_count,
  output int         pending,
  output int         beats_seen,
  output logic [5:0] verdicts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow tables
  logic [31:0]          rt_prefix [ROUTE_DEPTH];
  logic [31:0]          rt_mask   [ROUTE_DEPTH];
  logic [31:0]          rt_hop    [ROUTE_DEPTH];
  logic [PORT_BITS-1:0] rt_port   [ROUTE_DEPTH];
  bit                   rt_valid  [ROUTE_DEPTH];
  logic [31:0]          nb_ip     [NEIGHBOR_DEPTH];
  logic [47:0]          nb_mac    [NEIGHBOR_DEPTH];
  int                   nb_count;

  result_t awaited_answers [$];
  int      fails;
  int      beats;

  // Updates the shadow tables and returns the answer the block owes.
  function automatic result_t forward_decision(item_t it);
    result_t r;
    int      best;
    int      i;
    bit      hit;
    r = '0;
    case (it.action)
      ACT_ROUTE_WR: begin
        if (it.route_slot < ROUTE_DEPTH) begin
          rt_prefix[it.route_slot] = it.ip_value;
          rt_mask[it.route_slot]   = it.mask_value;
          rt_hop[it.route_slot]    = it.hop_address;
          rt_port[it.route_slot]   = it.port_number[PORT_BITS-1:0];
          rt_valid[it.route_slot]  = 1'b1;
        end
      end
      ACT_NBR_LEARN: begin
        if (nb_count < NEIGHBOR_DEPTH) begin
          nb_ip[nb_count]  = it.ip_value;
          nb_mac[nb_count] = it.mac_value;
          nb_count++;
        end else begin
          r.verdict = V_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (it.ttl_in <= 8'd1) begin
          r.verdict = V_TIME_EXCEEDED;
          r.ttl_out = it.ttl_in;
        end else begin
          best = -1;
          // unsigned mask rank; strict compare keeps the lowest index on ties
          for (i = 0; i < ROUTE_DEPTH; i++) begin
            if (rt_valid[i] && ((it.ip_value & rt_mask[i]) == rt_prefix[i])) begin
              if (best < 0 || rt_mask[i] > rt_mask[best]) best = i;
            end
          end
          if (best < 0) begin
            r.verdict = V_UNREACHABLE;
            r.ttl_out = it.ttl_in;
          end else begin
            r.verdict      = V_NEED_RESOLUTION;
            r.out_port     = 4'(rt_port[best]);
            r.next_hop_out = rt_hop[best];
            r.ttl_out      = it.ttl_in - 8'd1;
            hit = 1'b0;
            for (i = 0; i < nb_count && !hit; i++) begin
              if (nb_ip[i] == rt_hop[best]) begin
                hit          = 1'b1;
                r.verdict    = V_FORWARD;
                r.dest_mac   = nb_mac[i];
              end
            end
          end
        end
      end
      default: ;  // unused action: no state change, all-zero answer
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
    fails++;
  endtask

  task automatic compare_answer(result_t want, result_t got);
    if (got.verdict !== want.verdict)
      report_mismatch("verdict", 48'(got.verdict), 48'(want.verdict));
    if (got.out_port !== want.out_port)
      report_mismatch("out_port", 48'(got.out_port), 48'(want.out_port));
    if (got.next_hop_out !== want.next_hop_out)
      report_mismatch("next_hop_out", 48'(got.next_hop_out), 48'(want.next_hop_out));
    if (got.dest_mac !== want.dest_mac)
      report_mismatch("dest_mac", got.dest_mac, want.dest_mac);
    if (got.ttl_out !== want.ttl_out)
      report_mismatch("ttl_out", 48'(got.ttl_out), 48'(want.ttl_out));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      foreach (rt_valid[i]) rt_valid[i] = 1'b0;
      nb_count = 0;
      awaited_answers.delete();
      verdicts_seen <= '0;
    end else begin
      if (done === 1'b1) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected result, verdict", 48'(result.verdict), 48'd0);
        end else begin
          want = awaited_answers.pop_front();
          compare_answer(want, result);
          verdicts_seen[want.verdict] <= 1'b1;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_answers.push_back(forward_decision(item));
        beats++;
      end
    end
    fail_count <= fails;
    pending    <= awaited_answers.size();
    beats_seen <= beats;
  end

endmodule

// ===== test/tb_ipv4_forwarding_decision.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_forwarding_decision - top of the forwarding decision testbench
// Drives route writes, neighbor learns and lookups into the block: a short
// directed run over the corner cases, then random traffic built around the
// routes already written, under three sender idle mixes. Checking is done by
// ifd_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ipv4_forwarding_decision;
  timeunit 1ns;
  timeprecision 1ps;
  import ifd_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int BEATS_PER_MIX = 300;
  localparam int HOP_POOL      = 8;
  localparam int SETTLE_CYCLES = 90;   // longer than the slowest lookup

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    done;
  result_t result;

  int         fail_count;
  int         pending;
  int         beats_seen;
  logic [5:0] verdicts_seen;

  // Stimulus-side memory: which route slots hold what, so that lookups can
  // aim inside written prefixes. Also a small pool of next-hop addresses so
  // neighbor learns actually resolve routes.
  logic [31:0] hop_pool    [HOP_POOL];
  logic [31:0] known_prefix[ROUTE_DEPTH];
  logic [31:0] known_mask  [ROUTE_DEPTH];
  int          written_slots[$];
  int          idle_pct = 0;

  ipv4_forwarding_decision dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  ifd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .done          (done),
    .result        (result),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_seen    (beats_seen),
    .verdicts_seen (verdicts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Contiguous mask of the given length; length 0 is the default route.
  function automatic logic [31:0] len_mask(int len);
    return (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
  endfunction

  // Every field random, action included. Used as the base of all beats so
  // fields the action ignores still toggle.
  function automatic item_t noise_item();
    item_t it;
    it.action      = 2'($urandom_range(3));
    it.route_slot  = 6'($urandom);
    it.ip_value    = $urandom;
    it.mask_value  = $urandom;
    it.hop_address = $urandom;
    it.port_number = 4'($urandom);
    it.mac_value   = {16'($urandom), 32'($urandom)};
    it.ttl_in      = 8'($urandom);
    return it;
  endfunction

  function automatic item_t route_beat(int slot, logic [31:0] prefix, logic [31:0] mask,
                                       logic [31:0] hop, logic [3:0] port);
    item_t it;
    it = noise_item();
    it.action      = ACT_ROUTE_WR;
    it.route_slot  = 6'(slot);
    it.ip_value    = prefix;
    it.mask_value  = mask;
    it.hop_address = hop;
    it.port_number = port;
    return it;
  endfunction

  function automatic item_t learn_beat(logic [31:0] ip, logic [47:0] mac);
    item_t it;
    it = noise_item();
    it.action    = ACT_NBR_LEARN;
    it.ip_value  = ip;
    it.mac_value = mac;
    return it;
  endfunction

  function automatic item_t lookup_beat(logic [31:0] dst, logic [7:0] ttl);
    item_t it;
    it = noise_item();
    it.action   = ACT_LOOKUP;
    it.ip_value = dst;
    it.ttl_in   = ttl;
    return it;
  endfunction

  // Random traffic. Mostly well-formed: masks contiguous with the prefix
  // aligned, hops from the pool, lookups aimed inside a written route.
  // A slice is noise or malformed (odd masks, host bits in the prefix,
  // unknown neighbors, stray destinations, dying TTLs).
  function automatic item_t random_beat();
    item_t       it;
    int          pick;
    int          slot;
    logic [31:0] m;
    pick = $urandom_range(99);
    if (pick < 5) return noise_item();
    if (pick < 30) begin
      m = ($urandom_range(9) == 0) ? 32'($urandom) : len_mask($urandom_range(32));
      it = route_beat($urandom_range(ROUTE_DEPTH - 1), $urandom, m,
                      hop_pool[$urandom_range(HOP_POOL - 1)], 4'($urandom));
      if ($urandom_range(9) != 0) it.ip_value = it.ip_value & m;
      if ($urandom_range(9) == 0) it.hop_address = $urandom;
      return it;
    end
    if (pick < 40) begin
      it = learn_beat(hop_pool[$urandom_range(HOP_POOL - 1)], {16'($urandom), 32'($urandom)});
      if ($urandom_range(6) == 0) it.ip_value = $urandom;
      return it;
    end
    it = lookup_beat($urandom, 8'($urandom_range(2, 255)));
    if (written_slots.size() != 0 && $urandom_range(4) != 0) begin
      slot = written_slots[$urandom_range(written_slots.size() - 1)];
      it.ip_value = (known_prefix[slot] & known_mask[slot]) | ($urandom & ~known_mask[slot]);
    end
    if ($urandom_range(9) == 0) it.ttl_in = 8'($urandom_range(1));
    return it;
  endfunction

  // One beat: optional idle gap (start low), then hold start with the item
  // until an edge sees busy low. Returns at the falling edge after the
  // accepting edge, leaving start high so back-to-back beats need no glitch.
  task automatic send_beat(item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (it.action == ACT_ROUTE_WR) begin
      if (!(it.route_slot inside {written_slots})) written_slots.push_back(it.route_slot);
      known_prefix[it.route_slot] = it.ip_value;
      known_mask[it.route_slot]   = it.mask_value;
    end
  endtask

  // hard stop, well beyond the slowest legal run
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int mix;
    int n;
    hop_pool[0] = 32'hC0A8_0001;
    hop_pool[1] = 32'hC0A8_00FE;
    hop_pool[2] = 32'h0A00_0001;
    hop_pool[3] = 32'hAC10_0101;
    for (n = 4; n < HOP_POOL; n++) hop_pool[n] = $urandom;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed corners, no idling ---
    // empty table: unreachable; then both dying TTLs and the unused action
    send_beat(lookup_beat(32'h0A01_0203, 8'd64));
    send_beat(lookup_beat(32'h0A01_0203, 8'd0));
    send_beat(lookup_beat(32'h0A01_0203, 8'd1));
    begin
      item_t odd;
      odd = noise_item();
      odd.action = ACT_UNUSED;
      send_beat(odd);
    end
    // default route, /8 in the top slot, two equal /16 (lowest index wins),
    // a non-contiguous mask and a host route with all-ones fields
    send_beat(route_beat(0, 32'h0, 32'h0, hop_pool[0], 4'hF));
    send_beat(route_beat(63, 32'h0A00_0000, len_mask(8), hop_pool[1], 4'h0));
    send_beat(route_beat(5, 32'h0A01_0000, len_mask(16), hop_pool[2], 4'h3));
    send_beat(route_beat(6, 32'h0A01_0000, len_mask(16), hop_pool[0], 4'h9));
    send_beat(route_beat(7, 32'hC000_A800, 32'hFF00_FF00, hop_pool[1], 4'h6));
    send_beat(route_beat(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    // no neighbors yet: need resolution, including TTL 2 -> 1
    send_beat(lookup_beat(32'h0A01_0203, 8'd255));
    send_beat(lookup_beat(32'h0A01_0203, 8'd2));
    // duplicate neighbor address: the first learned MAC must win
    send_beat(learn_beat(hop_pool[2], 48'hFFFF_FFFF_FFFF));
    send_beat(learn_beat(hop_pool[2], 48'h0));
    send_beat(lookup_beat(32'h0A01_0203, 8'd255));
    send_beat(lookup_beat(32'h0A7F_0001, 8'd64));
    send_beat(lookup_beat(32'hC012_A834, 8'd30));
    send_beat(lookup_beat(32'hFFFF_FFFF, 8'd255));
    send_beat(lookup_beat(32'h0808_0808, 8'd255));
    send_beat(learn_beat(hop_pool[0], 48'h0123_4567_89AB));
    send_beat(lookup_beat(32'h0808_0808, 8'd128));
    send_beat(learn_beat(32'hFFFF_FFFF, 48'hFEDC_BA98_7654));
    send_beat(lookup_beat(32'hFFFF_FFFF, 8'd3));
    // overwrite slot 5 with a /24 under the same /16
    send_beat(route_beat(5, 32'h0A01_0200, len_mask(24), hop_pool[1], 4'hA));
    send_beat(lookup_beat(32'h0A01_0203, 8'd100));

    // --- random traffic: light idling, heavy idling, none ---
    // The neighbor table fills early here, after which learns must report full.
    for (mix = 0; mix < 3; mix++) begin
      idle_pct = (mix == 0) ? 7 : (mix == 1) ? 80 : 0;
      for (n = 0; n < BEATS_PER_MIX; n++) send_beat(random_beat());
    end
    start <= 1'b0;

    // drain, then let any stray result show up
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d beats (directed corners, then random traffic at 7%%, 80%% and",
             beats_seen);
    $display("no sender idling); verdict codes seen, 5 down to 0: %b", verdicts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
